// ===== hdl/edrt_pkg.sv =====
package edrt_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] ACT_CHS_READ   = 2'd0;
    localparam logic [1:0] ACT_CHS_VERIFY = 2'd1;
    localparam logic [1:0] ACT_EXT_READ   = 2'd2;
    localparam logic [1:0] ACT_EXT_VERIFY = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMULATION_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_NUMBER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_TRACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE        = 3'd5;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // mask bits of the pieces of a split read
    localparam int PIECE_HEAD = 0;
    localparam int PIECE_MID  = 1;
    localparam int PIECE_TAIL = 2;

    // one request after the split, ready for the result expander
    typedef struct packed {
        logic [2:0]  mask;      // pieces still to issue; zero means status only
        logic        status;
        logic [31:0] head_lba;
        logic [31:0] mid_lba;
        logic [1:0]  skip;
        logic [1:0]  take;
        logic [13:0] mid;
        logic [1:0]  tail;
    } split_t;

    typedef struct packed {
        logic        is_command;
        logic [31:0] medium_lba;
        logic [13:0] medium_count;
        logic        via_bounce;
        logic [1:0]  skip_quarters;
        logic [1:0]  copy_quarters;
        logic        status;
        logic        last;
    } result_t;

endpackage

// ===== hdl/edrt_expander.sv =====
module edrt_expander (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  edrt_pkg::split_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output edrt_pkg::result_t out_res
);

    logic             valid_reg, valid_next;
    logic [2:0]       mask_reg, mask_next;
    logic             status_reg;
    logic [31:0]      head_lba_reg, mid_lba_reg, tail_lba_reg;
    logic [1:0]       before_reg, take_reg, tail_reg;
    logic [13:0]      mid_reg;
    logic             last;
    logic             load;

    assign last      = (mask_reg & (mask_reg - 3'd1)) == 3'd0;
    assign in_ready  = !valid_reg || (out_ready && last);
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        mask_next  = mask_reg;
        if (load) begin
            valid_next = 1'b1;
            mask_next  = in_item.mask;
        end else if (valid_reg && out_ready) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                mask_next = mask_reg & (mask_reg - 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mask_reg  <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg   <= in_item.status;
            head_lba_reg <= in_item.head_lba;
            mid_lba_reg  <= in_item.mid_lba;
            tail_lba_reg <= in_item.mid_lba + {18'd0, in_item.mid};
            before_reg   <= in_item.skip;
            take_reg     <= in_item.take;
            mid_reg      <= in_item.mid;
            tail_reg     <= in_item.tail;
        end
    end

    // lowest pending piece goes out first
    always_comb begin
        out_res = '0;
        out_res.last = last;
        if (mask_reg[edrt_pkg::PIECE_HEAD]) begin
            out_res.is_command    = 1'b1;
            out_res.medium_lba    = head_lba_reg;
            out_res.medium_count  = 14'd1;
            out_res.via_bounce    = 1'b1;
            out_res.skip_quarters = before_reg;
            out_res.copy_quarters = take_reg;
        end else if (mask_reg[edrt_pkg::PIECE_MID]) begin
            out_res.is_command   = 1'b1;
            out_res.medium_lba   = mid_lba_reg;
            out_res.medium_count = mid_reg;
        end else if (mask_reg[edrt_pkg::PIECE_TAIL]) begin
            out_res.is_command    = 1'b1;
            out_res.medium_lba    = tail_lba_reg;
            out_res.medium_count  = 14'd1;
            out_res.via_bounce    = 1'b1;
            out_res.copy_quarters = tail_reg;
        end else begin
            out_res.status = status_reg;
        end
    end

endmodule

// ===== hdl/emulated_disk_read_translator.sv =====
// Read-request translator for a 512-byte-sector disk emulated on 2048-byte
// medium sectors.
// s_* : one request per transfer. s_tuser carries the action, s_tdata the
//       drive, CHS address, count and extended LBA.
// m_* : one to three results per request: head bounce read, aligned middle
//       read, tail bounce read, or a single status result. m_tlast marks the
//       final result of a request; status is only meaningful there.
// cfg_* : register writes (index, data); always ready. The user must write
//         them only while idle; the block itself does not enforce this.
// Pipeline: stage registers geometry product, sector product, LBA select,
// split and base add, the first loaded by the input transfer; then the
// result register.
// Throughput: one request per cycle while each gives one result and m_tready
// is high; a request with more results holds the result register to its last.
// Stalls: m_tready low freezes the result register and the pipeline fills
// behind it; s_tready drops only once every stage holds a request.
// Reset: synchronous active-low aresetn empties the pipeline and clears all
// configuration registers, which disables emulation.
module emulated_disk_read_translator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // drive[7:0] cylinder[17:8] head[25:18] sector[31:26] count[47:32]
    // ext_lba[79:48] ext_lba_high_set[80], zero fill above
    input  logic [87:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // medium_lba[31:0] medium_count[45:32] via_bounce[46] skip_quarters[48:47]
    // copy_quarters[50:49] status[51], zero fill above
    output logic [55:0] m_tdata,
    // is_command[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic        emulation_on_reg;
    logic [7:0]  drive_number_reg;
    logic [5:0]  sectors_per_track_reg;
    logic [10:0] cylinder_count_reg;
    logic [8:0]  head_count_reg;
    logic [31:0] image_base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emulation_on_reg      <= 1'b0;
            drive_number_reg      <= 8'd0;
            sectors_per_track_reg <= 6'd0;
            cylinder_count_reg    <= 11'd0;
            head_count_reg        <= 9'd0;
            image_base_reg        <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                edrt_pkg::CFG_EMULATION_ON:      emulation_on_reg      <= cfg_data[0];
                edrt_pkg::CFG_DRIVE_NUMBER:      drive_number_reg      <= cfg_data[7:0];
                edrt_pkg::CFG_SECTORS_PER_TRACK: sectors_per_track_reg <= cfg_data[5:0];
                edrt_pkg::CFG_CYLINDER_COUNT:    cylinder_count_reg    <= cfg_data[10:0];
                edrt_pkg::CFG_HEAD_COUNT:        head_count_reg        <= cfg_data[8:0];
                edrt_pkg::CFG_IMAGE_BASE:        image_base_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // input unpack
    logic [1:0]  in_action;
    logic [7:0]  in_drive;
    logic [9:0]  in_cylinder;
    logic [7:0]  in_head;
    logic [5:0]  in_sector;
    logic [15:0] in_count;
    logic [31:0] in_ext_lba;
    logic        in_high;

    assign in_action   = s_tuser;
    assign in_drive    = s_tdata[7:0];
    assign in_cylinder = s_tdata[17:8];
    assign in_head     = s_tdata[25:18];
    assign in_sector   = s_tdata[31:26];
    assign in_count    = s_tdata[47:32];
    assign in_ext_lba  = s_tdata[79:48];
    assign in_high     = s_tdata[80];

    // request checks: a status-only outcome is settled here
    logic is_chs;
    logic status_only;
    logic status_val;
    logic geom_bad;

    assign is_chs   = (in_action == edrt_pkg::ACT_CHS_READ)
                   || (in_action == edrt_pkg::ACT_CHS_VERIFY);
    assign geom_bad = (in_sector > sectors_per_track_reg)
                   || ({1'b0, in_cylinder} >= cylinder_count_reg)
                   || ({1'b0, in_head} >= head_count_reg);

    always_comb begin
        status_only = 1'b0;
        status_val  = edrt_pkg::STATUS_OK;
        if (!emulation_on_reg || in_drive != drive_number_reg) begin
            status_only = 1'b1;
            status_val  = edrt_pkg::STATUS_INVALID;
        end else if (is_chs) begin
            if (in_count[7:0] == 8'd0) begin
                status_only = 1'b1;
            end else if (geom_bad) begin
                status_only = 1'b1;
                status_val  = edrt_pkg::STATUS_INVALID;
            end else if (in_action == edrt_pkg::ACT_CHS_VERIFY) begin
                status_only = 1'b1;
            end
        end else if (in_high) begin
            status_only = 1'b1;
            status_val  = edrt_pkg::STATUS_INVALID;
        end else if (in_action == edrt_pkg::ACT_EXT_VERIFY) begin
            status_only = 1'b1;
        end
    end

    // stage enables
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic en_a, en_b, en_c, en_d;
    logic exp_ready;

    assign en_d     = !d_valid_reg || exp_ready;
    assign en_c     = !c_valid_reg || en_d;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= s_tvalid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
            if (en_d) d_valid_reg <= c_valid_reg;
        end
    end

    // stage A: cylinder * head_count
    logic        a_so_reg, a_st_reg, a_chs_reg;
    logic [7:0]  a_head_reg;
    logic [5:0]  a_sector_reg;
    logic [15:0] a_count_reg;
    logic [31:0] a_elba_reg;
    logic [18:0] a_p1_reg;
    logic [18:0] p1_next;

    assign p1_next = {9'd0, in_cylinder} * {10'd0, head_count_reg};

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_so_reg     <= status_only;
            a_st_reg     <= status_val;
            a_chs_reg    <= is_chs;
            a_head_reg   <= in_head;
            a_sector_reg <= in_sector;
            a_count_reg  <= in_count;
            a_elba_reg   <= in_ext_lba;
            a_p1_reg     <= p1_next;
        end
    end

    // stage B: (product + head) * sectors_per_track
    logic        b_so_reg, b_st_reg, b_chs_reg;
    logic [5:0]  b_sector_reg;
    logic [15:0] b_count_reg;
    logic [31:0] b_elba_reg;
    logic [25:0] b_p2_reg;
    logic [19:0] track_next;
    logic [25:0] p2_next;

    assign track_next = {1'b0, a_p1_reg} + {12'd0, a_head_reg};
    assign p2_next    = {6'd0, track_next} * {20'd0, sectors_per_track_reg};

    always_ff @(posedge aclk) begin
        if (en_b) begin
            b_so_reg     <= a_so_reg;
            b_st_reg     <= a_st_reg;
            b_chs_reg    <= a_chs_reg;
            b_sector_reg <= a_sector_reg;
            b_count_reg  <= a_count_reg;
            b_elba_reg   <= a_elba_reg;
            b_p2_reg     <= p2_next;
        end
    end

    // stage C: virtual LBA (sector zero wraps) and sector count
    logic        c_so_reg, c_st_reg;
    logic [31:0] c_lba_reg, lba_next;
    logic [15:0] c_n_reg, n_next;

    always_comb begin
        if (b_chs_reg) begin
            lba_next = {6'd0, b_p2_reg} + {26'd0, b_sector_reg} - 32'd1;
            n_next   = {8'd0, b_count_reg[7:0]};
        end else begin
            lba_next = b_elba_reg;
            n_next   = b_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_so_reg  <= b_so_reg;
            c_st_reg  <= b_st_reg;
            c_lba_reg <= lba_next;
            c_n_reg   <= n_next;
        end
    end

    // stage D: split into head, middle and tail
    edrt_pkg::split_t d_item_reg, split_next;
    logic [1:0]  head_skip;
    logic [2:0]  room;
    logic [1:0]  take;
    logic [15:0] rest;
    logic [31:0] base_slba;

    assign head_skip = c_lba_reg[1:0];
    assign room      = 3'd4 - {1'b0, head_skip};
    assign take      = (head_skip == 2'd0) ? 2'd0
                     : (c_n_reg < {13'd0, room}) ? c_n_reg[1:0] : room[1:0];
    assign rest      = c_n_reg - {14'd0, take};
    assign base_slba = image_base_reg + {2'd0, c_lba_reg[31:2]};

    always_comb begin
        split_next          = '0;
        split_next.status   = c_st_reg;
        split_next.head_lba = base_slba;
        split_next.mid_lba  = base_slba + {31'd0, (head_skip != 2'd0)};
        split_next.skip     = head_skip;
        split_next.take     = take;
        split_next.mid      = rest[15:2];
        split_next.tail     = rest[1:0];
        if (!c_so_reg) begin
            split_next.mask[edrt_pkg::PIECE_HEAD] = head_skip != 2'd0;
            split_next.mask[edrt_pkg::PIECE_MID]  = rest[15:2] != 14'd0;
            split_next.mask[edrt_pkg::PIECE_TAIL] = rest[1:0] != 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            d_item_reg <= split_next;
        end
    end

    // stage E: one result per transfer
    edrt_pkg::result_t res;

    edrt_expander u_expander (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid_reg),
        .in_ready  (exp_ready),
        .in_item   (d_item_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'd0, res.status, res.copy_quarters, res.skip_quarters,
                      res.via_bounce, res.medium_count, res.medium_lba};
    assign m_tuser = res.is_command;
    assign m_tlast = res.last;

    // only the final result of a request may be other than a command
    a_nonlast_is_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.last |-> res.is_command)
        else $error("non-final result is not a command");

    // a failing status never rides on a command
    a_status_placement: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status |-> res.last && !res.is_command)
        else $error("status set on a command result");

    // a direct read carries no quarter counts
    a_direct_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.is_command && !res.via_bounce
        |-> res.skip_quarters == 2'd0 && res.copy_quarters == 2'd0
            && res.medium_count != 14'd0)
        else $error("direct read with bounce fields");

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !d_valid_reg)
        else $error("valid after reset");

endmodule
